[rtl/sorted_priority_queue_assert.svh]
// Assertion macros for the sorted priority queue checker.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH
// Consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/spq_pkg.sv]
// Shared types and constants for the sorted priority queue.
`default_nettype none
package spq_pkg;
    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int TAG_W  = 16;
    localparam int PRIO_W = 16;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [2:0] {
        FN_ENQ    = 3'd0,
        FN_DEQ    = 3'd1,
        FN_PEEK   = 3'd2,
        FN_GET    = 3'd3,
        FN_CHANGE = 3'd4,
        FN_RANGE  = 3'd5,
        FN_CLEAR  = 3'd6
    } func_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TAKEN    = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4,
        ST_AMBIG    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE,
        S_PLACE,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
        logic [PRIO_W-1:0] hi;
    } key_t;

    typedef struct packed {
        logic prio_eq;
        logic prio_gt;
        logic tag_eq;
        logic in_range;
    } cmp_t;

    typedef struct packed {
        logic   we;
        idx_t   waddr;
        entry_t wdata;
        idx_t   raddr;
    } mem_req_t;
endpackage
`default_nettype wire

[rtl/spq_store.sv]
// Entry store: one write port, one registered read port.
`default_nettype none
module spq_store (
    input  logic              clk,
    input  spq_pkg::mem_req_t req,
    output spq_pkg::entry_t   rdata
);
    spq_pkg::entry_t store_mem [spq_pkg::DEPTH];
    spq_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            store_mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= store_mem[req.raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

[rtl/spq_cmp.sv]
// Shared compare unit: one stored entry against the operation key.
`default_nettype none
module spq_cmp (
    input  spq_pkg::entry_t entry,
    input  spq_pkg::key_t   key,
    output spq_pkg::cmp_t   res
);
    assign res.prio_eq  = (entry.prio == key.prio);
    assign res.prio_gt  = (entry.prio > key.prio);
    assign res.tag_eq   = (entry.tag == key.tag);
    assign res.in_range = (entry.prio >= key.prio) && (entry.prio <= key.hi);
endmodule
`default_nettype wire

[rtl/spq_ctrl.sv]
// Sequencer: scan, shift and place passes over the store, result register.
`default_nettype none
module spq_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  func,
    input  logic [spq_pkg::TAG_W-1:0]   tag,
    input  logic [spq_pkg::PRIO_W-1:0]  prio,
    input  logic [spq_pkg::PRIO_W-1:0]  high_bound,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  status,
    output logic [spq_pkg::TAG_W-1:0]   out_tag,
    output logic [spq_pkg::PRIO_W-1:0]  out_prio,
    output logic [spq_pkg::CNT_W-1:0]   removed,
    output logic [spq_pkg::CNT_W-1:0]   count,
    output spq_pkg::mem_req_t           mem_req,
    input  spq_pkg::entry_t             rdata,
    output spq_pkg::key_t               key,
    input  spq_pkg::cmp_t               cmp
);
    // control state
    spq_pkg::state_t state_reg, state_next;
    spq_pkg::cnt_t   fill_reg, fill_next;
    logic            dv_reg, dv_next;
    logic            out_valid_reg, out_valid_next;

    // operation and pass registers
    spq_pkg::func_t  op_reg, op_next;
    spq_pkg::key_t   key_reg, key_next;
    spq_pkg::idx_t   rd_idx_reg, rd_idx_next;
    spq_pkg::cnt_t   rd_left_reg, rd_left_next;
    spq_pkg::idx_t   dat_idx_reg, dat_idx_next;
    spq_pkg::cnt_t   wr_ptr_reg, wr_ptr_next;
    logic            down_reg, down_next;
    logic            place_reg, place_next;
    spq_pkg::idx_t   place_idx_reg, place_idx_next;

    // scan accumulators
    logic                        taken_reg, taken_next;
    spq_pkg::cnt_t               pos_reg, pos_next;
    logic [1:0]                  hits_reg, hits_next;
    spq_pkg::idx_t               at_reg, at_next;
    logic [spq_pkg::PRIO_W-1:0]  at_prio_reg, at_prio_next;
    spq_pkg::entry_t             head_reg, head_next;
    spq_pkg::cnt_t               rem_cnt_reg, rem_cnt_next;

    // pending result and output register
    spq_pkg::status_t            res_status_reg, res_status_next;
    logic [spq_pkg::TAG_W-1:0]   res_tag_reg, res_tag_next;
    logic [spq_pkg::PRIO_W-1:0]  res_prio_reg, res_prio_next;
    spq_pkg::status_t            status_reg, status_next;
    logic [spq_pkg::TAG_W-1:0]   out_tag_reg, out_tag_next;
    logic [spq_pkg::PRIO_W-1:0]  out_prio_reg, out_prio_next;
    spq_pkg::cnt_t               removed_reg, removed_next;
    spq_pkg::cnt_t               count_reg, count_next;

    // end-of-scan decision
    spq_pkg::status_t            dec_status;
    logic [spq_pkg::TAG_W-1:0]   dec_tag;
    logic [spq_pkg::PRIO_W-1:0]  dec_prio;
    spq_pkg::cnt_t               dec_fill;
    logic                        dec_move;
    logic                        dec_down;
    spq_pkg::idx_t               dec_rd_idx;
    spq_pkg::cnt_t               dec_rd_left;
    spq_pkg::cnt_t               dec_wr;
    logic                        dec_place;
    spq_pkg::idx_t               dec_place_idx;
    spq_pkg::cnt_t               pos_new;
    spq_pkg::cnt_t               at_ext;

    logic accept;
    logic pass_done;
    logic resp_go;

    assign accept    = in_valid && (state_reg == spq_pkg::S_IDLE);
    assign pass_done = (rd_left_reg == '0) && !dv_reg;
    assign resp_go   = !out_valid_reg || out_ready;
    assign key       = key_reg;

    assign in_ready  = (state_reg == spq_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_tag   = out_tag_reg;
    assign out_prio  = out_prio_reg;
    assign removed   = removed_reg;
    assign count     = count_reg;

    // Decide the outcome once the scan has seen every held entry.
    always_comb
    begin
        dec_status    = spq_pkg::ST_OK;
        dec_tag       = '0;
        dec_prio      = '0;
        dec_fill      = fill_reg;
        dec_move      = 1'b0;
        dec_down      = 1'b0;
        dec_rd_idx    = '0;
        dec_rd_left   = '0;
        dec_wr        = '0;
        dec_place     = 1'b0;
        dec_place_idx = '0;
        at_ext        = spq_pkg::cnt_t'(at_reg);
        // the moved entry no longer counts toward the insert position
        pos_new       = pos_reg - spq_pkg::cnt_t'(at_prio_reg > key_reg.prio);
        unique case (op_reg)
            spq_pkg::FN_ENQ:
            begin
                if (taken_reg)
                begin
                    dec_status = spq_pkg::ST_TAKEN;
                end
                else if (fill_reg == spq_pkg::cnt_t'(spq_pkg::DEPTH))
                begin
                    dec_status = spq_pkg::ST_FULL;
                end
                else
                begin
                    dec_fill      = fill_reg + spq_pkg::cnt_t'(1);
                    dec_place     = 1'b1;
                    dec_place_idx = spq_pkg::idx_t'(pos_reg);
                    if (pos_reg < fill_reg)
                    begin
                        dec_move    = 1'b1;
                        dec_down    = 1'b1;
                        dec_rd_idx  = spq_pkg::idx_t'(fill_reg - spq_pkg::cnt_t'(1));
                        dec_rd_left = fill_reg - pos_reg;
                        dec_wr      = fill_reg;
                    end
                end
            end
            spq_pkg::FN_DEQ, spq_pkg::FN_PEEK:
            begin
                if (fill_reg == '0)
                begin
                    dec_status = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    dec_tag  = head_reg.tag;
                    dec_prio = head_reg.prio;
                    if (op_reg == spq_pkg::FN_DEQ)
                    begin
                        dec_fill = fill_reg - spq_pkg::cnt_t'(1);
                        if (fill_reg > spq_pkg::cnt_t'(1))
                        begin
                            dec_move    = 1'b1;
                            dec_rd_idx  = spq_pkg::idx_t'(1);
                            dec_rd_left = fill_reg - spq_pkg::cnt_t'(1);
                            dec_wr      = '0;
                        end
                    end
                end
            end
            spq_pkg::FN_GET:
            begin
                if (hits_reg == '0)
                begin
                    dec_status = spq_pkg::ST_NOTFOUND;
                end
                else
                begin
                    dec_prio = at_prio_reg;
                end
            end
            spq_pkg::FN_CHANGE:
            begin
                if (taken_reg)
                begin
                    dec_status = spq_pkg::ST_TAKEN;
                end
                else if (hits_reg[1])
                begin
                    dec_status = spq_pkg::ST_AMBIG;
                end
                else if (hits_reg == '0)
                begin
                    dec_status = spq_pkg::ST_NOTFOUND;
                end
                else
                begin
                    dec_place     = 1'b1;
                    dec_place_idx = spq_pkg::idx_t'(pos_new);
                    if (at_ext < pos_new)
                    begin
                        // close the gap upward, then place below
                        dec_move    = 1'b1;
                        dec_rd_idx  = at_reg + spq_pkg::idx_t'(1);
                        dec_rd_left = pos_new - at_ext;
                        dec_wr      = at_ext;
                    end
                    else if (at_ext > pos_new)
                    begin
                        dec_move    = 1'b1;
                        dec_down    = 1'b1;
                        dec_rd_idx  = at_reg - spq_pkg::idx_t'(1);
                        dec_rd_left = at_ext - pos_new;
                        dec_wr      = at_ext;
                    end
                end
            end
            spq_pkg::FN_RANGE:
            begin
                dec_fill = wr_ptr_reg;
            end
            default:
            begin
                dec_status = spq_pkg::ST_OK;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (spq_pkg::func_t'(func))
                        spq_pkg::FN_ENQ, spq_pkg::FN_DEQ, spq_pkg::FN_PEEK,
                        spq_pkg::FN_GET, spq_pkg::FN_CHANGE, spq_pkg::FN_RANGE:
                            state_next = spq_pkg::S_SCAN;
                        default:
                            state_next = spq_pkg::S_RESP;
                    endcase
                end
            end
            spq_pkg::S_SCAN:
            begin
                if (pass_done)
                begin
                    if (dec_move)
                    begin
                        state_next = spq_pkg::S_MOVE;
                    end
                    else if (dec_place)
                    begin
                        state_next = spq_pkg::S_PLACE;
                    end
                    else
                    begin
                        state_next = spq_pkg::S_RESP;
                    end
                end
            end
            spq_pkg::S_MOVE:
            begin
                if (pass_done)
                begin
                    state_next = place_reg ? spq_pkg::S_PLACE : spq_pkg::S_RESP;
                end
            end
            spq_pkg::S_PLACE:
            begin
                state_next = spq_pkg::S_RESP;
            end
            spq_pkg::S_RESP:
            begin
                if (resp_go)
                begin
                    state_next = spq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = spq_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory requests
    always_comb
    begin
        fill_next       = fill_reg;
        dv_next         = 1'b0;
        out_valid_next  = out_valid_reg && !out_ready;
        op_next         = op_reg;
        key_next        = key_reg;
        rd_idx_next     = rd_idx_reg;
        rd_left_next    = rd_left_reg;
        dat_idx_next    = dat_idx_reg;
        wr_ptr_next     = wr_ptr_reg;
        down_next       = down_reg;
        place_next      = place_reg;
        place_idx_next  = place_idx_reg;
        taken_next      = taken_reg;
        pos_next        = pos_reg;
        hits_next       = hits_reg;
        at_next         = at_reg;
        at_prio_next    = at_prio_reg;
        head_next       = head_reg;
        rem_cnt_next    = rem_cnt_reg;
        res_status_next = res_status_reg;
        res_tag_next    = res_tag_reg;
        res_prio_next   = res_prio_reg;
        status_next     = status_reg;
        out_tag_next    = out_tag_reg;
        out_prio_next   = out_prio_reg;
        removed_next    = removed_reg;
        count_next      = count_reg;
        mem_req.we      = 1'b0;
        mem_req.waddr   = spq_pkg::idx_t'(wr_ptr_reg);
        mem_req.wdata   = rdata;
        mem_req.raddr   = rd_idx_reg;

        // issue one read a cycle while a pass has entries left
        if ((state_reg == spq_pkg::S_SCAN) || (state_reg == spq_pkg::S_MOVE))
        begin
            if (rd_left_reg != '0)
            begin
                dv_next      = 1'b1;
                dat_idx_next = rd_idx_reg;
                rd_left_next = rd_left_reg - spq_pkg::cnt_t'(1);
                rd_idx_next  = down_reg ? (rd_idx_reg - spq_pkg::idx_t'(1))
                                        : (rd_idx_reg + spq_pkg::idx_t'(1));
            end
        end

        unique case (state_reg)
            spq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = spq_pkg::func_t'(func);
                    key_next.tag    = tag;
                    key_next.prio   = prio;
                    key_next.hi     = high_bound;
                    rd_idx_next     = '0;
                    rd_left_next    = fill_reg;
                    wr_ptr_next     = '0;
                    down_next       = 1'b0;
                    place_next      = 1'b0;
                    taken_next      = 1'b0;
                    pos_next        = '0;
                    hits_next       = '0;
                    rem_cnt_next    = '0;
                    res_status_next = spq_pkg::ST_OK;
                    res_tag_next    = '0;
                    res_prio_next   = '0;
                    if (spq_pkg::func_t'(func) == spq_pkg::FN_CLEAR)
                    begin
                        rem_cnt_next = fill_reg;
                        fill_next    = '0;
                    end
                end
            end
            spq_pkg::S_SCAN:
            begin
                if (dv_reg)
                begin
                    taken_next = taken_reg || cmp.prio_eq;
                    pos_next   = pos_reg + spq_pkg::cnt_t'(cmp.prio_gt);
                    if (cmp.tag_eq)
                    begin
                        if (hits_reg == '0)
                        begin
                            at_next      = dat_idx_reg;
                            at_prio_next = rdata.prio;
                        end
                        if (!hits_reg[1])
                        begin
                            hits_next = hits_reg + 2'd1;
                        end
                    end
                    if (dat_idx_reg == '0)
                    begin
                        head_next = rdata;
                    end
                    // range removal compacts the kept entries in place
                    if (op_reg == spq_pkg::FN_RANGE)
                    begin
                        if (cmp.in_range)
                        begin
                            rem_cnt_next = rem_cnt_reg + spq_pkg::cnt_t'(1);
                        end
                        else
                        begin
                            mem_req.we  = 1'b1;
                            wr_ptr_next = wr_ptr_reg + spq_pkg::cnt_t'(1);
                        end
                    end
                end
                if (pass_done)
                begin
                    res_status_next = dec_status;
                    res_tag_next    = dec_tag;
                    res_prio_next   = dec_prio;
                    fill_next       = dec_fill;
                    rd_idx_next     = dec_rd_idx;
                    rd_left_next    = dec_rd_left;
                    wr_ptr_next     = dec_wr;
                    down_next       = dec_down;
                    place_next      = dec_place;
                    place_idx_next  = dec_place_idx;
                end
            end
            spq_pkg::S_MOVE:
            begin
                if (dv_reg)
                begin
                    mem_req.we  = 1'b1;
                    wr_ptr_next = down_reg ? (wr_ptr_reg - spq_pkg::cnt_t'(1))
                                           : (wr_ptr_reg + spq_pkg::cnt_t'(1));
                end
            end
            spq_pkg::S_PLACE:
            begin
                mem_req.we         = 1'b1;
                mem_req.waddr      = place_idx_reg;
                mem_req.wdata.tag  = key_reg.tag;
                mem_req.wdata.prio = key_reg.prio;
            end
            spq_pkg::S_RESP:
            begin
                if (resp_go)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    out_tag_next   = res_tag_reg;
                    out_prio_next  = res_prio_reg;
                    removed_next   = rem_cnt_reg;
                    count_next     = fill_reg;
                end
            end
            default:
            begin
                dv_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spq_pkg::S_IDLE;
            fill_reg      <= '0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            dv_reg        <= dv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        rd_idx_reg     <= rd_idx_next;
        rd_left_reg    <= rd_left_next;
        dat_idx_reg    <= dat_idx_next;
        wr_ptr_reg     <= wr_ptr_next;
        down_reg       <= down_next;
        place_reg      <= place_next;
        place_idx_reg  <= place_idx_next;
        taken_reg      <= taken_next;
        pos_reg        <= pos_next;
        hits_reg       <= hits_next;
        at_reg         <= at_next;
        at_prio_reg    <= at_prio_next;
        head_reg       <= head_next;
        rem_cnt_reg    <= rem_cnt_next;
        res_status_reg <= res_status_next;
        res_tag_reg    <= res_tag_next;
        res_prio_reg   <= res_prio_next;
        status_reg     <= status_next;
        out_tag_reg    <= out_tag_next;
        out_prio_reg   <= out_prio_next;
        removed_reg    <= removed_next;
        count_reg      <= count_next;
    end
endmodule
`default_nettype wire

[rtl/sorted_priority_queue.sv]
// Clear and the unused code answer without a pass over the store; peek, lookup and range
// removal scan every held entry; enqueue, change and dequeue may also shift entries.
// Throughput: one operation at a time; the next is taken the cycle after the result
// registers, so the one-entry-a-cycle scan and shift passes over the single read port set it.
// Reset: asynchronous, active low; empties the queue, drops any pending result, keeps store data.
`default_nettype none
module sorted_priority_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  func,
    input  logic [spq_pkg::TAG_W-1:0]   tag,
    input  logic [spq_pkg::PRIO_W-1:0]  prio,
    input  logic [spq_pkg::PRIO_W-1:0]  high_bound,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  status,
    output logic [spq_pkg::TAG_W-1:0]   out_tag,
    output logic [spq_pkg::PRIO_W-1:0]  out_prio,
    output logic [spq_pkg::CNT_W-1:0]   removed,
    output logic [spq_pkg::CNT_W-1:0]   count
);
    spq_pkg::mem_req_t mem_req;
    spq_pkg::entry_t   rdata;
    spq_pkg::key_t     key;
    spq_pkg::cmp_t     cmp;

    spq_store u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    spq_cmp u_cmp (
        .entry (rdata),
        .key   (key),
        .res   (cmp)
    );

    spq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .tag        (tag),
        .prio       (prio),
        .high_bound (high_bound),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .out_tag    (out_tag),
        .out_prio   (out_prio),
        .removed    (removed),
        .count      (count),
        .mem_req    (mem_req),
        .rdata      (rdata),
        .key        (key),
        .cmp        (cmp)
    );
endmodule
`default_nettype wire

[rtl/spq_checker.sv]
// Port-level assertions for the sorted priority queue, bound to the top level.
`default_nettype none
module spq_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [2:0]                  status,
    input logic [spq_pkg::TAG_W-1:0]   out_tag,
    input logic [spq_pkg::PRIO_W-1:0]  out_prio,
    input logic [spq_pkg::CNT_W-1:0]   removed,
    input logic [spq_pkg::CNT_W-1:0]   count
);
`include "sorted_priority_queue_assert.svh"

    // a stalled result beat holds
    `SPQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(status) && $stable(count) && $stable(out_prio),
        "stalled result changed")

    // an accepted operation closes the input in the following cycle
    `SPQ_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
        "input ready right after accept")

    `SPQ_ASSERT_NOW(a_empty_result, out_valid && (status == spq_pkg::ST_EMPTY),
        (count == '0) && (out_tag == '0) && (out_prio == '0), "empty result not clean")

    `SPQ_ASSERT_NOW(a_full_count, out_valid && (status == spq_pkg::ST_FULL),
        count == spq_pkg::cnt_t'(spq_pkg::DEPTH), "full status with room left")

    `SPQ_ASSERT_NOW(a_fail_no_removal, out_valid && (status != spq_pkg::ST_OK),
        removed == '0, "failed operation reports removals")
endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);
`default_nettype wire

[tb/tb_sorted_priority_queue.sv]
// Self-checking testbench for the sorted priority queue: random and directed operations.
`timescale 1ns / 100ps
`default_nettype none
module tb_sorted_priority_queue;
    localparam logic [2:0] FN_SPARE   = 3'd7;
    localparam int         IDLE_LIMIT = 4000;
    localparam int         TAIL_WAIT  = 60;
    localparam int         RAND_ITEMS = 950;

    typedef logic [spq_pkg::TAG_W-1:0]  tag_word_t;
    typedef logic [spq_pkg::PRIO_W-1:0] prio_word_t;

    typedef struct {
        logic [2:0]                 func;
        logic [spq_pkg::TAG_W-1:0]  tag;
        logic [spq_pkg::PRIO_W-1:0] prio;
        logic [spq_pkg::PRIO_W-1:0] hi;
        bit                         hold;
    } op_t;

    typedef struct {
        logic [2:0]                 status;
        logic [spq_pkg::TAG_W-1:0]  out_tag;
        logic [spq_pkg::PRIO_W-1:0] out_prio;
        spq_pkg::cnt_t              removed;
        spq_pkg::cnt_t              count;
    } result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [2:0]                 func = 3'd0;
    logic [spq_pkg::TAG_W-1:0]  tag = '0;
    logic [spq_pkg::PRIO_W-1:0] prio = '0;
    logic [spq_pkg::PRIO_W-1:0] high_bound = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [2:0]                 status;
    logic [spq_pkg::TAG_W-1:0]  out_tag;
    logic [spq_pkg::PRIO_W-1:0] out_prio;
    spq_pkg::cnt_t              removed;
    spq_pkg::cnt_t              count;

    sorted_priority_queue u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .tag        (tag),
        .prio       (prio),
        .high_bound (high_bound),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .out_tag    (out_tag),
        .out_prio   (out_prio),
        .removed    (removed),
        .count      (count)
    );

    op_t                        pending_ops[$];
    result_t                    expected_results[$];
    logic [spq_pkg::PRIO_W-1:0] q_prio[spq_pkg::DEPTH];
    logic [spq_pkg::TAG_W-1:0]  q_tag[spq_pkg::DEPTH];
    int                         q_fill = 0;
    int                         err_cnt = 0;
    int                         ops_sent = 0;
    int                         results_seen = 0;
    int                         full_hits = 0;
    int                         ambig_hits = 0;
    int                         taken_hits = 0;
    int                         range_drops = 0;
    int                         cyc = 0;
    int                         idle_cycles = 0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Quiet windows: no new gaps or stalls start on either side.
    wire quiet = (cyc % 1500) < 300;

    function automatic bit prio_held(logic [spq_pkg::PRIO_W-1:0] p);
        for (int i = 0; i < q_fill; i++)
        begin
            if (q_prio[i] == p)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void insert_entry(logic [spq_pkg::TAG_W-1:0] t,
                                         logic [spq_pkg::PRIO_W-1:0] p);
        int pos;
        pos = 0;
        while (pos < q_fill && q_prio[pos] > p)
            pos++;
        for (int i = q_fill; i > pos; i--)
        begin
            q_prio[i] = q_prio[i-1];
            q_tag[i]  = q_tag[i-1];
        end
        q_prio[pos] = p;
        q_tag[pos]  = t;
        q_fill++;
    endfunction

    function automatic void drop_entry(int pos);
        for (int i = pos; i + 1 < q_fill; i++)
        begin
            q_prio[i] = q_prio[i+1];
            q_tag[i]  = q_tag[i+1];
        end
        q_fill--;
    endfunction

    // Apply one operation to the shadow store and return what the block should answer.
    function automatic result_t predict_result(op_t op);
        result_t r;
        int      hits;
        int      at;
        int      i;
        r.status   = spq_pkg::ST_OK;
        r.out_tag  = '0;
        r.out_prio = '0;
        r.removed  = '0;
        case (op.func)
            spq_pkg::FN_ENQ:
            begin
                if (prio_held(op.prio))
                    r.status = spq_pkg::ST_TAKEN;
                else if (q_fill >= spq_pkg::DEPTH)
                    r.status = spq_pkg::ST_FULL;
                else
                    insert_entry(op.tag, op.prio);
            end
            spq_pkg::FN_DEQ, spq_pkg::FN_PEEK:
            begin
                if (q_fill == 0)
                    r.status = spq_pkg::ST_EMPTY;
                else
                begin
                    r.out_tag  = q_tag[0];
                    r.out_prio = q_prio[0];
                    if (op.func == spq_pkg::FN_DEQ)
                        drop_entry(0);
                end
            end
            spq_pkg::FN_GET:
            begin
                r.status = spq_pkg::ST_NOTFOUND;
                for (i = 0; i < q_fill; i++)
                begin
                    if (q_tag[i] == op.tag)
                    begin
                        r.status   = spq_pkg::ST_OK;
                        r.out_prio = q_prio[i];
                        break;
                    end
                end
            end
            spq_pkg::FN_CHANGE:
            begin
                hits = 0;
                at   = 0;
                for (i = 0; i < q_fill; i++)
                begin
                    if (q_tag[i] == op.tag)
                    begin
                        if (hits == 0)
                            at = i;
                        hits++;
                    end
                end
                if (prio_held(op.prio))
                    r.status = spq_pkg::ST_TAKEN;
                else if (hits > 1)
                    r.status = spq_pkg::ST_AMBIG;
                else if (hits == 0)
                    r.status = spq_pkg::ST_NOTFOUND;
                else
                begin
                    drop_entry(at);
                    insert_entry(op.tag, op.prio);
                end
            end
            spq_pkg::FN_RANGE:
            begin
                i = 0;
                while (i < q_fill)
                begin
                    if (q_prio[i] >= op.prio && q_prio[i] <= op.hi)
                    begin
                        drop_entry(i);
                        r.removed++;
                    end
                    else
                        i++;
                end
            end
            spq_pkg::FN_CLEAR:
            begin
                r.removed = spq_pkg::cnt_t'(q_fill);
                q_fill    = 0;
            end
            default:
            begin
            end
        endcase
        r.count = spq_pkg::cnt_t'(q_fill);
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Small pools make duplicate tags and taken priorities common.
    function automatic logic [spq_pkg::TAG_W-1:0] pick_tag();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return tag_word_t'($urandom_range(0, 5));
        else if (roll == 6)
            return {spq_pkg::TAG_W{1'b1}};
        else
            return tag_word_t'($urandom_range(0, 65535));
    endfunction

    function automatic logic [spq_pkg::PRIO_W-1:0] pick_prio();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 10)
            return prio_word_t'($urandom_range(0, 40));
        else if (roll < 12)
            return prio_word_t'({spq_pkg::PRIO_W{1'b1}} - $urandom_range(0, 3));
        else
            return prio_word_t'($urandom_range(0, 65535));
    endfunction

    task automatic add_op(logic [2:0] f, logic [spq_pkg::TAG_W-1:0] t,
                          logic [spq_pkg::PRIO_W-1:0] p,
                          logic [spq_pkg::PRIO_W-1:0] h, bit hold);
        op_t op;
        op.func = f;
        op.tag  = t;
        op.prio = p;
        op.hi   = h;
        op.hold = hold;
        pending_ops.push_back(op);
    endtask

    task automatic add_mixed(bit hold_first);
        int                         roll;
        logic [spq_pkg::PRIO_W-1:0] lo;
        logic [spq_pkg::PRIO_W-1:0] up;
        logic [2:0]                 f;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            f = spq_pkg::FN_ENQ;
        else if (roll < 40)
            f = spq_pkg::FN_DEQ;
        else if (roll < 48)
            f = spq_pkg::FN_PEEK;
        else if (roll < 62)
            f = spq_pkg::FN_GET;
        else if (roll < 80)
            f = spq_pkg::FN_CHANGE;
        else if (roll < 93)
            f = spq_pkg::FN_RANGE;
        else if (roll < 96)
            f = spq_pkg::FN_CLEAR;
        else
            f = FN_SPARE;
        lo = pick_prio();
        roll = $urandom_range(0, 9);
        if (roll < 6)
            up = prio_word_t'(lo + $urandom_range(0, 30));
        else if (roll < 8)
            up = prio_word_t'($urandom_range(0, 65535));
        else
            up = prio_word_t'(lo - $urandom_range(1, 20));
        add_op(f, pick_tag(), lo, up, hold_first);
    endtask

    task automatic build_stimulus();
        int                        mode;
        int                        n;
        logic [spq_pkg::TAG_W-1:0] t;
        // Directed part: empty store first, then the conflict and move cases.
        add_op(spq_pkg::FN_DEQ,    16'h0000, 16'h0000, 16'h0000, 1'b0);
        add_op(spq_pkg::FN_PEEK,   16'hffff, 16'hffff, 16'hffff, 1'b0);
        add_op(spq_pkg::FN_GET,    16'h0000, 16'h0000, 16'h0000, 1'b0);
        add_op(spq_pkg::FN_CHANGE, 16'h0000, 16'h0005, 16'h0000, 1'b0);
        add_op(spq_pkg::FN_RANGE,  16'h0000, 16'h0000, 16'hffff, 1'b0);
        add_op(spq_pkg::FN_CLEAR,  16'h0000, 16'h0000, 16'h0000, 1'b0);
        add_op(FN_SPARE,           16'hffff, 16'hffff, 16'hffff, 1'b0);
        add_op(spq_pkg::FN_ENQ,    16'hffff, 16'hffff, 16'h0000, 1'b0);
        add_op(spq_pkg::FN_ENQ,    16'h0000, 16'h0000, 16'h0000, 1'b0);
        add_op(spq_pkg::FN_ENQ,    16'h1234, 16'h0000, 16'h0000, 1'b0);
        add_op(spq_pkg::FN_ENQ,    16'hffff, 16'd100,  16'h0000, 1'b0);
        add_op(spq_pkg::FN_GET,    16'hffff, 16'h0000, 16'h0000, 1'b0);
        add_op(spq_pkg::FN_CHANGE, 16'hffff, 16'd300,  16'h0000, 1'b0);
        add_op(spq_pkg::FN_CHANGE, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        add_op(spq_pkg::FN_CHANGE, 16'h0000, 16'd200,  16'h0000, 1'b0);
        add_op(spq_pkg::FN_PEEK,   16'h0000, 16'h0000, 16'h0000, 1'b0);
        add_op(spq_pkg::FN_RANGE,  16'h0000, 16'd300,  16'd50,   1'b0);
        add_op(spq_pkg::FN_RANGE,  16'h0000, 16'd150,  16'd250,  1'b0);
        add_op(spq_pkg::FN_DEQ,    16'h0000, 16'h0000, 16'h0000, 1'b0);
        add_op(FN_SPARE,           16'h0000, 16'h0000, 16'h0000, 1'b0);
        add_op(spq_pkg::FN_CLEAR,  16'h0000, 16'h0000, 16'h0000, 1'b1);

        while (pending_ops.size() < RAND_ITEMS)
        begin
            mode = $urandom_range(0, 9);
            case (mode)
                4, 5:
                begin
                    // Fill run: push past a full store, then poke at it.
                    n = $urandom_range(14, 20);
                    for (int i = 0; i < n; i++)
                        add_op(spq_pkg::FN_ENQ, pick_tag(),
                               prio_word_t'($urandom_range(0, 65535)),
                               prio_word_t'($urandom_range(0, 65535)), 1'b0);
                    for (int i = 0; i < 4; i++)
                        add_mixed(1'b0);
                end
                6:
                begin
                    // Duplicate tag: ambiguous change, then resolve it.
                    t = tag_word_t'($urandom_range(0, 65535));
                    add_op(spq_pkg::FN_ENQ, t, prio_word_t'(16'd1000 + $urandom_range(0, 99)),
                           16'h0000, 1'b0);
                    add_op(spq_pkg::FN_ENQ, t, prio_word_t'(16'd1200 + $urandom_range(0, 99)),
                           16'h0000, 1'b0);
                    add_op(spq_pkg::FN_CHANGE, t, prio_word_t'($urandom_range(0, 65535)),
                           16'h0000, 1'b0);
                    add_op(spq_pkg::FN_GET, t, 16'h0000, 16'h0000, 1'b0);
                    add_op(spq_pkg::FN_RANGE, 16'h0000, 16'd1200, 16'd1299, 1'b0);
                    add_op(spq_pkg::FN_CHANGE, t, prio_word_t'($urandom_range(0, 65535)),
                           16'h0000, 1'b0);
                    add_op(spq_pkg::FN_PEEK, t, 16'h0000, 16'h0000, 1'b0);
                end
                7:
                begin
                    n = $urandom_range(5, 18);
                    for (int i = 0; i < n; i++)
                        add_op(($urandom_range(0, 4) == 0) ? spq_pkg::FN_PEEK : spq_pkg::FN_DEQ,
                               pick_tag(), pick_prio(), pick_prio(), 1'b0);
                end
                8:
                begin
                    add_op(spq_pkg::FN_CLEAR, pick_tag(), pick_prio(), pick_prio(), 1'b0);
                    for (int i = 0; i < 6; i++)
                        add_mixed(1'b0);
                end
                default:
                begin
                    n = $urandom_range(10, 30);
                    for (int i = 0; i < n; i++)
                        add_mixed(mode == 9 && i == 0);
                end
            endcase
        end
    endtask

    // Driver: present the next pending op once the previous beat and its gap are done.
    always @(posedge clk or negedge rst_n)
    begin : drv
        op_t     nxt;
        op_t     cur;
        result_t r;
        bit      busy;
        int      gap_left;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            func       <= 3'd0;
            tag        <= '0;
            prio       <= '0;
            high_bound <= '0;
            gap_left   = 0;
        end
        else
        begin
            busy = in_valid;
            if (in_valid && in_ready)
            begin
                cur.func = func;
                cur.tag  = tag;
                cur.prio = prio;
                cur.hi   = high_bound;
                cur.hold = 1'b0;
                r = predict_result(cur);
                if (r.status == spq_pkg::ST_FULL)
                    full_hits++;
                if (r.status == spq_pkg::ST_AMBIG)
                    ambig_hits++;
                if (r.status == spq_pkg::ST_TAKEN)
                    taken_hits++;
                if (func == spq_pkg::FN_RANGE && r.removed != 0)
                    range_drops++;
                expected_results.push_back(r);
                ops_sent++;
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_ops.size() > 0 &&
                         (!pending_ops[0].hold || expected_results.size() == 0))
                begin
                    nxt = pending_ops.pop_front();
                    func       <= nxt.func;
                    tag        <= nxt.tag;
                    prio       <= nxt.prio;
                    high_bound <= nxt.hi;
                    in_valid   <= 1'b1;
                    gap_left   = pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    // Monitor: check each result beat against the oldest prediction; stall at random.
    always @(posedge clk or negedge rst_n)
    begin : mon
        result_t exp_r;
        int      stall_left;
        logic    nxt_ready;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none actual status %h count %h",
                             $time, status, count);
                    err_cnt++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    check_field("status",   16'(exp_r.status),   16'(status));
                    check_field("out_tag",  exp_r.out_tag,       out_tag);
                    check_field("out_prio", exp_r.out_prio,      out_prio);
                    check_field("removed",  16'(exp_r.removed),  16'(removed));
                    check_field("count",    16'(exp_r.count),    16'(count));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                nxt_ready = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
                nxt_ready  = (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
            else
                nxt_ready = 1'b1;
            out_ready <= nxt_ready;
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: timeout, %0d ops pending, %0d results outstanding",
                         $time, pending_ops.size(), expected_results.size());
                $display("FAIL sorted_priority_queue");
                $finish;
            end
        end
    end

    initial
    begin
        build_stimulus();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        if (expected_results.size() > 0)
            err_cnt++;
        $display("Ran %0d operations, checked %0d results, %0d errors.",
                 ops_sent, results_seen, err_cnt);
        $display("Store full %0d times, taken priority %0d, ambiguous tag %0d, range drops %0d.",
                 full_hits, taken_hits, ambig_hits, range_drops);
        if (err_cnt == 0)
            $display("PASS sorted_priority_queue");
        else
            $display("FAIL sorted_priority_queue");
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_store.sv
rtl/spq_cmp.sv
rtl/spq_ctrl.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
tb/tb_sorted_priority_queue.sv
